>>> hdl/krb_pkg.sv
package krb_pkg;

    localparam int MAX_LISTS_DEF = 256;
    localparam int SLOTS_DEF     = 32;

    localparam int MODE_W    = 2;
    localparam int LIST_W    = 8;
    localparam int COUNT_W   = 6;
    localparam int KEY_W     = 32;
    localparam int PAYLOAD_W = 32;
    localparam int OSLOT_W   = 5;

    typedef enum logic [MODE_W-1:0] {
        MODE_OPEN    = 2'd0,
        MODE_INSERT  = 2'd1,
        MODE_DELIVER = 2'd2,
        MODE_NONE    = 2'd3
    } t_mode;

endpackage

>>> hdl/krb_ram.sv
module krb_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                                  i_clk,
    input  logic                                  i_we,
    input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] i_waddr,
    input  logic [WIDTH-1:0]                      i_wdata,
    input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] i_raddr,
    output logic [WIDTH-1:0]                      o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata <= r_mem[i_raddr];
    end

endmodule

>>> hdl/keyed_reorder_buffer_commit.sv
// keyed reorder buffer with in-order commit
// input channel: i_in_valid / o_in_stall carries one operation per transaction:
//   open a list with a slot count, insert a key into its sorted key column,
//   or deliver a payload by key
// output channel: o_out_valid / i_out_stall carries committed entries in key
//   order; o_run_last marks the final entry released by one delivery
// one operation is in flight at a time; o_in_stall is high while it runs
// steps per operation, n = list slot count:
//   open: clears one flag-memory row per cycle, for all SLOTS rows
//   insert: list read, then up to n slot steps, shifting larger keys up
//   deliver: list read, binary search (up to log2(n) + 1 probes), payload
//     write, then a commit walk that waits while the receiver stalls
// insert, search, deliver and walk steps read a single-port-read memory,
// then evaluate and write back; that read-modify-write pair sets the rate
// no clearing pass after reset: list state has one valid flop per list, and
// slot flags are cleared when a list is opened
// a stalled receiver holds the output register; the commit walk waits for it
module keyed_reorder_buffer_commit #(
    parameter int MAX_LISTS = krb_pkg::MAX_LISTS_DEF,
    parameter int SLOTS     = krb_pkg::SLOTS_DEF
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_in_valid,
    output logic                          o_in_stall,
    input  logic [krb_pkg::MODE_W-1:0]    i_mode,
    input  logic [krb_pkg::LIST_W-1:0]    i_list_id,
    input  logic [krb_pkg::COUNT_W-1:0]   i_slot_count,
    input  logic [krb_pkg::KEY_W-1:0]     i_entry_key,
    input  logic [krb_pkg::PAYLOAD_W-1:0] i_payload_in,
    output logic                          o_out_valid,
    input  logic                          i_out_stall,
    output logic [krb_pkg::LIST_W-1:0]    o_out_list,
    output logic [krb_pkg::OSLOT_W-1:0]   o_out_slot,
    output logic [krb_pkg::KEY_W-1:0]     o_out_key,
    output logic [krb_pkg::PAYLOAD_W-1:0] o_out_payload,
    output logic                          o_run_last
);

    localparam int LW = (MAX_LISTS > 1) ? $clog2(MAX_LISTS) : 1;
    localparam int SW = (SLOTS > 1) ? $clog2(SLOTS) : 1;
    localparam int CW = $clog2(SLOTS + 1);
    localparam int KW = krb_pkg::KEY_W;
    localparam int PW = krb_pkg::PAYLOAD_W;
    localparam int SDEPTH = MAX_LISTS * (2 ** SW);

    typedef enum logic [3:0] {
        S_IDLE, S_OPEN_CLR, S_LIST_RD, S_LIST_EV, S_INS_RD, S_INS_EV,
        S_SRCH_RD, S_SRCH_EV, S_DLV_RD, S_DLV_EV, S_WALK_RD, S_WALK_EV, S_FINISH
    } t_state;

    t_state r_state;
    logic [MAX_LISTS-1:0] r_lvalid;
    logic [krb_pkg::MODE_W-1:0] r_mode;
    logic [krb_pkg::LIST_W-1:0] r_list;
    logic [LW-1:0] r_lidx;
    logic [CW-1:0] r_cnt, r_n, r_idx, r_lo, r_hp;
    logic [KW-1:0] r_key;
    logic [PW-1:0] r_payload;
    logic [SW-1:0] r_j, r_pos;
    logic          r_carry;
    logic [KW:0]   r_carry_key;
    logic          r_pend;
    logic [SW-1:0] r_pend_slot;
    logic [KW-1:0] r_pend_key;
    logic [PW-1:0] r_pend_payload;
    logic          r_out_valid;

    logic          lm_we;
    logic [2*CW-1:0] lm_wdata, lm_rdata;
    logic          km_we;
    logic [SW-1:0] km_wslot, sm_wslot, rd_slot;
    logic [KW:0]   km_wdata, km_rdata;
    logic          sm_we;
    logic [PW+1:0] sm_wdata, sm_rdata;

    logic          in_accept, out_free, in_range, out_load;
    logic [CW-1:0] sat_cnt, mid;
    logic [CW:0]   mid_sum;
    logic          last_j;

    assign in_accept = i_in_valid && (r_state == S_IDLE);
    assign o_in_stall = (r_state != S_IDLE);
    assign out_free = !r_out_valid || !i_out_stall;
    assign o_out_valid = r_out_valid;
    assign out_load = out_free && r_pend
        && (((r_state == S_WALK_EV) && sm_rdata[PW+1]) || (r_state == S_FINISH));
    assign in_range = ({24'd0, i_list_id} < 32'(MAX_LISTS));
    assign sat_cnt = (32'(i_slot_count) > 32'(SLOTS)) ? CW'(SLOTS) : CW'(i_slot_count);
    assign mid_sum = {1'b0, r_lo} + {1'b0, r_hp} - (CW+1)'(1);
    assign mid = mid_sum[CW:1];
    assign last_j = ((CW'(r_j) + CW'(1)) == r_n);

    krb_ram #(.WIDTH(2*CW), .DEPTH(MAX_LISTS)) u_list_ram (
        .i_clk(i_clk), .i_we(lm_we), .i_waddr(r_lidx), .i_wdata(lm_wdata),
        .i_raddr(r_lidx), .o_rdata(lm_rdata)
    );

    krb_ram #(.WIDTH(KW+1), .DEPTH(SDEPTH)) u_key_ram (
        .i_clk(i_clk), .i_we(km_we), .i_waddr({r_lidx, km_wslot}), .i_wdata(km_wdata),
        .i_raddr({r_lidx, rd_slot}), .o_rdata(km_rdata)
    );

    krb_ram #(.WIDTH(PW+2), .DEPTH(SDEPTH)) u_slot_ram (
        .i_clk(i_clk), .i_we(sm_we), .i_waddr({r_lidx, sm_wslot}), .i_wdata(sm_wdata),
        .i_raddr({r_lidx, rd_slot}), .o_rdata(sm_rdata)
    );

    // memory control
    always_comb begin
        lm_we = 1'b0;
        lm_wdata = {r_n, r_idx};
        km_we = 1'b0;
        km_wslot = r_j;
        km_wdata = {1'b1, r_key};
        sm_we = 1'b0;
        sm_wslot = r_pos;
        sm_wdata = {2'b10, r_payload};
        rd_slot = r_j;
        case (r_state)
            S_OPEN_CLR: begin
                lm_we = 1'b1;
                lm_wdata = {r_cnt, CW'(0)};
                km_we = 1'b1;
                km_wdata = {1'b0, r_key};
                sm_we = 1'b1;
                sm_wslot = r_j;
                sm_wdata = {2'b00, r_payload};
            end
            S_INS_EV: begin
                if (r_carry) begin
                    km_we = 1'b1;
                    km_wdata = r_carry_key;
                end else if (!km_rdata[KW] || (km_rdata[KW-1:0] > r_key)) begin
                    km_we = 1'b1;
                end
            end
            S_SRCH_RD: rd_slot = SW'(mid);
            S_SRCH_EV: rd_slot = r_pos;
            S_DLV_RD, S_DLV_EV: begin
                rd_slot = r_pos;
                sm_we = (r_state == S_DLV_EV) && !sm_rdata[PW];
            end
            S_WALK_RD, S_WALK_EV: begin
                rd_slot = SW'(r_idx);
                sm_wslot = SW'(r_idx);
                sm_wdata = {2'b11, sm_rdata[PW-1:0]};
                sm_we = (r_state == S_WALK_EV) && sm_rdata[PW+1] && (!r_pend || out_free);
            end
            S_FINISH: lm_we = 1'b1;
            default: ;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_lvalid <= '0;
            r_pend <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (out_load) begin
                r_out_valid <= 1'b1;
            end else if (r_out_valid && !i_out_stall) begin
                r_out_valid <= 1'b0;
            end
            unique case (r_state)
                S_IDLE: begin
                    if (in_accept) begin
                        r_mode <= i_mode;
                        r_list <= i_list_id;
                        r_lidx <= LW'(i_list_id);
                        r_cnt <= sat_cnt;
                        r_key <= i_entry_key;
                        r_payload <= i_payload_in;
                        r_j <= '0;
                        r_carry <= 1'b0;
                        if (in_range && (i_mode == krb_pkg::MODE_OPEN)) begin
                            r_state <= S_OPEN_CLR;
                        end else if (in_range && ((i_mode == krb_pkg::MODE_INSERT)
                                || (i_mode == krb_pkg::MODE_DELIVER))) begin
                            r_state <= S_LIST_RD;
                        end
                    end
                end
                S_OPEN_CLR: begin
                    r_lvalid[r_lidx] <= 1'b1;
                    r_j <= r_j + SW'(1);
                    if (CW'(r_j) == CW'(SLOTS - 1)) begin
                        r_state <= S_IDLE;
                    end
                end
                S_LIST_RD: r_state <= S_LIST_EV;
                S_LIST_EV: begin
                    r_n <= r_lvalid[r_lidx] ? lm_rdata[2*CW-1:CW] : '0;
                    r_idx <= r_lvalid[r_lidx] ? lm_rdata[CW-1:0] : '0;
                    r_lo <= '0;
                    r_hp <= r_lvalid[r_lidx] ? lm_rdata[2*CW-1:CW] : '0;
                    if (!r_lvalid[r_lidx] || (lm_rdata[2*CW-1:CW] == '0)) begin
                        r_state <= S_IDLE;
                    end else if (r_mode == krb_pkg::MODE_INSERT) begin
                        r_state <= S_INS_RD;
                    end else begin
                        r_state <= S_SRCH_RD;
                    end
                end
                S_INS_RD: r_state <= S_INS_EV;
                S_INS_EV: begin
                    if (r_carry || !km_rdata[KW] || (km_rdata[KW-1:0] > r_key)) begin
                        r_carry <= 1'b1;
                        r_carry_key <= km_rdata;
                        if (!km_rdata[KW] || last_j) begin
                            r_state <= S_IDLE;
                        end else begin
                            r_j <= r_j + SW'(1);
                            r_state <= S_INS_RD;
                        end
                    end else if (last_j) begin
                        r_state <= S_IDLE;
                    end else begin
                        r_j <= r_j + SW'(1);
                        r_state <= S_INS_RD;
                    end
                end
                S_SRCH_RD: begin
                    r_pos <= SW'(mid);
                    r_state <= (r_lo < r_hp) ? S_SRCH_EV : S_WALK_RD;
                end
                S_SRCH_EV: begin
                    if (km_rdata[KW] && (km_rdata[KW-1:0] == r_key)) begin
                        r_state <= S_DLV_RD;
                    end else begin
                        if (km_rdata[KW] && (km_rdata[KW-1:0] < r_key)) begin
                            r_lo <= CW'(r_pos) + CW'(1);
                        end else begin
                            r_hp <= CW'(r_pos);
                        end
                        r_state <= S_SRCH_RD;
                    end
                end
                S_DLV_RD: r_state <= S_DLV_EV;
                S_DLV_EV: r_state <= sm_rdata[PW] ? S_IDLE : S_WALK_RD;
                S_WALK_RD: r_state <= (r_idx < r_n) ? S_WALK_EV : S_FINISH;
                S_WALK_EV: begin
                    if (!sm_rdata[PW+1]) begin
                        r_state <= S_FINISH;
                    end else if (!r_pend || out_free) begin
                        if (r_pend) begin
                            o_out_list <= r_list;
                            o_out_slot <= krb_pkg::OSLOT_W'(r_pend_slot);
                            o_out_key <= r_pend_key;
                            o_out_payload <= r_pend_payload;
                            o_run_last <= 1'b0;
                        end
                        r_pend <= 1'b1;
                        r_pend_slot <= SW'(r_idx);
                        r_pend_key <= km_rdata[KW-1:0];
                        r_pend_payload <= sm_rdata[PW-1:0];
                        r_idx <= r_idx + CW'(1);
                        r_state <= S_WALK_RD;
                    end
                end
                S_FINISH: begin
                    if (!r_pend) begin
                        r_state <= S_IDLE;
                    end else if (out_free) begin
                        o_out_list <= r_list;
                        o_out_slot <= krb_pkg::OSLOT_W'(r_pend_slot);
                        o_out_key <= r_pend_key;
                        o_out_payload <= r_pend_payload;
                        o_run_last <= 1'b1;
                        r_pend <= 1'b0;
                        r_state <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

endmodule

>>> dv/krb_commit_checker.sv
`timescale 1ns / 100ps

module krb_commit_checker (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_in_valid,
    input  logic                          i_in_stall,
    input  logic [krb_pkg::MODE_W-1:0]    i_mode,
    input  logic [krb_pkg::LIST_W-1:0]    i_list_id,
    input  logic [krb_pkg::COUNT_W-1:0]   i_slot_count,
    input  logic [krb_pkg::KEY_W-1:0]     i_entry_key,
    input  logic [krb_pkg::PAYLOAD_W-1:0] i_payload_in,
    input  logic                          i_out_valid,
    input  logic                          i_out_stall,
    input  logic [krb_pkg::LIST_W-1:0]    i_out_list,
    input  logic [krb_pkg::OSLOT_W-1:0]   i_out_slot,
    input  logic [krb_pkg::KEY_W-1:0]     i_out_key,
    input  logic [krb_pkg::PAYLOAD_W-1:0] i_out_payload,
    input  logic                          i_run_last,
    output int                            o_fail_cnt,
    output int                            o_pending,
    output int                            o_commits
);

    localparam int NLISTS    = krb_pkg::MAX_LISTS_DEF;
    localparam int NSLOTS    = krb_pkg::SLOTS_DEF;
    localparam int LIST_W    = krb_pkg::LIST_W;
    localparam int OSLOT_W   = krb_pkg::OSLOT_W;
    localparam int COUNT_W   = krb_pkg::COUNT_W;
    localparam int KEY_W     = krb_pkg::KEY_W;
    localparam int PAYLOAD_W = krb_pkg::PAYLOAD_W;

    typedef struct {
        logic [LIST_W-1:0]    lst;
        logic [OSLOT_W-1:0]   slot;
        logic [KEY_W-1:0]     key;
        logic [PAYLOAD_W-1:0] payload;
        logic                 last;
    } t_commit;

    t_commit commit_q[$];

    logic [COUNT_W-1:0]   list_len [NLISTS];
    logic [COUNT_W-1:0]   commit_ptr [NLISTS];
    logic [KEY_W-1:0]     key_col [NLISTS][NSLOTS];
    logic [PAYLOAD_W-1:0] pay_col [NLISTS][NSLOTS];
    bit                   has_key [NLISTS][NSLOTS];
    bit                   has_pay [NLISTS][NSLOTS];
    bit                   released [NLISTS][NSLOTS];

    int fails = 0;
    int commits = 0;

    assign o_fail_cnt = fails;
    assign o_commits  = commits;

    initial begin
        o_pending = 0;
        for (int l = 0; l < NLISTS; l++) begin
            list_len[l]   = '0;
            commit_ptr[l] = '0;
            for (int s = 0; s < NSLOTS; s++) begin
                has_key[l][s]  = 0;
                has_pay[l][s]  = 0;
                released[l][s] = 0;
            end
        end
    end

    function automatic void insert_sorted(int l, logic [KEY_W-1:0] key);
        int n;
        bit placed;
        n = list_len[l];
        placed = 0;
        for (int i = 0; i < n && !placed; i++) begin
            if (!has_key[l][i]) begin
                key_col[l][i] = key;
                has_key[l][i] = 1;
                placed = 1;
            end else if (key_col[l][i] > key) begin
                for (int j = n - 1; j > i; j--) begin
                    key_col[l][j] = key_col[l][j-1];
                    has_key[l][j] = has_key[l][j-1];
                end
                key_col[l][i] = key;
                has_key[l][i] = 1;
                placed = 1;
            end
        end
    endfunction

    function automatic int search_key(int l, logic [KEY_W-1:0] key);
        int lo, hi, mid, pos;
        lo = 0;
        hi = int'(list_len[l]) - 1;
        pos = -1;
        while (lo <= hi && pos < 0) begin
            mid = lo + (hi - lo) / 2;
            if (has_key[l][mid] && key_col[l][mid] == key) pos = mid;
            else if (has_key[l][mid] && key_col[l][mid] < key) lo = mid + 1;
            else hi = mid - 1;
        end
        return pos;
    endfunction

    function automatic void predict_op(krb_pkg::t_mode mode, int l, int cnt,
                                       logic [KEY_W-1:0] key, logic [PAYLOAD_W-1:0] pay);
        int pos, idx, nrel;
        t_commit c;
        case (mode)
            krb_pkg::MODE_OPEN: begin
                list_len[l]   = COUNT_W'((cnt > NSLOTS) ? NSLOTS : cnt);
                commit_ptr[l] = '0;
                for (int s = 0; s < NSLOTS; s++) begin
                    has_key[l][s]  = 0;
                    has_pay[l][s]  = 0;
                    released[l][s] = 0;
                end
            end
            krb_pkg::MODE_INSERT: insert_sorted(l, key);
            krb_pkg::MODE_DELIVER: begin
                if (list_len[l] != 0) begin
                    pos = search_key(l, key);
                    if (!(pos >= 0 && released[l][pos])) begin
                        if (pos >= 0) begin
                            pay_col[l][pos] = pay;
                            has_pay[l][pos] = 1;
                        end
                        idx = commit_ptr[l];
                        nrel = 0;
                        while (idx < list_len[l] && has_pay[l][idx]) begin
                            c.lst     = LIST_W'(l);
                            c.slot    = OSLOT_W'(idx);
                            c.key     = key_col[l][idx];
                            c.payload = pay_col[l][idx];
                            c.last    = 0;
                            commit_q.push_back(c);
                            released[l][idx] = 1;
                            idx++;
                            nrel++;
                        end
                        commit_ptr[l] = COUNT_W'(idx);
                        if (nrel > 0) commit_q[$].last = 1;
                    end
                end
            end
            default: ;
        endcase
    endfunction

    always @(posedge i_clk) begin
        t_commit e;
        if (i_rst_n) begin
            if (i_out_valid && !i_out_stall) begin
                commits++;
                if (commit_q.size() == 0) begin
                    $error("unexpected commit: list %0d slot %0d", i_out_list, i_out_slot);
                    fails++;
                end else begin
                    e = commit_q.pop_front();
                    if (i_out_list !== e.lst) begin
                        $error("out_list expected %0d actual %0d", e.lst, i_out_list);
                        fails++;
                    end
                    if (i_out_slot !== e.slot) begin
                        $error("out_slot expected %0d actual %0d", e.slot, i_out_slot);
                        fails++;
                    end
                    if (i_out_key !== e.key) begin
                        $error("out_key expected %h actual %h", e.key, i_out_key);
                        fails++;
                    end
                    if (i_out_payload !== e.payload) begin
                        $error("out_payload expected %h actual %h", e.payload, i_out_payload);
                        fails++;
                    end
                    if (i_run_last !== e.last) begin
                        $error("run_last expected %0d actual %0d", e.last, i_run_last);
                        fails++;
                    end
                end
            end
            if (i_in_valid && !i_in_stall)
                predict_op(krb_pkg::t_mode'(i_mode), i_list_id, i_slot_count, i_entry_key,
                           i_payload_in);
        end
        o_pending = commit_q.size();
    end

endmodule

>>> dv/keyed_reorder_buffer_commit_tb.sv
`timescale 1ns / 100ps

module keyed_reorder_buffer_commit_tb;

    localparam int MODE_W    = krb_pkg::MODE_W;
    localparam int LIST_W    = krb_pkg::LIST_W;
    localparam int COUNT_W   = krb_pkg::COUNT_W;
    localparam int KEY_W     = krb_pkg::KEY_W;
    localparam int PAYLOAD_W = krb_pkg::PAYLOAD_W;
    localparam int OSLOT_W   = krb_pkg::OSLOT_W;

    logic                 i_clk = 0;
    logic                 i_rst_n = 0;
    logic                 i_in_valid = 0;
    logic                 o_in_stall;
    logic [MODE_W-1:0]    i_mode = '0;
    logic [LIST_W-1:0]    i_list_id = '0;
    logic [COUNT_W-1:0]   i_slot_count = '0;
    logic [KEY_W-1:0]     i_entry_key = '0;
    logic [PAYLOAD_W-1:0] i_payload_in = '0;
    logic                 o_out_valid;
    logic                 i_out_stall = 0;
    logic [LIST_W-1:0]    o_out_list;
    logic [OSLOT_W-1:0]   o_out_slot;
    logic [KEY_W-1:0]     o_out_key;
    logic [PAYLOAD_W-1:0] o_out_payload;
    logic                 o_run_last;

    int fail_cnt, pending, commits;
    int ops_sent = 0;
    int quiet_cycles = 0;
    int hold_cnt = 0;
    bit quiet = 0;
    bit hold_go = 0;
    bit hold_done = 0;

    always #5 i_clk = ~i_clk;

    keyed_reorder_buffer_commit dut (.*);

    krb_commit_checker checker_i (
        .i_clk, .i_rst_n, .i_in_valid, .i_in_stall(o_in_stall), .i_mode, .i_list_id,
        .i_slot_count, .i_entry_key, .i_payload_in, .i_out_valid(o_out_valid), .i_out_stall,
        .i_out_list(o_out_list), .i_out_slot(o_out_slot), .i_out_key(o_out_key),
        .i_out_payload(o_out_payload), .i_run_last(o_run_last),
        .o_fail_cnt(fail_cnt), .o_pending(pending), .o_commits(commits)
    );

    // receiver: random stalls, one long hold-off
    always @(posedge i_clk) begin
        if (hold_cnt > 0) begin
            hold_cnt <= hold_cnt - 1;
            i_out_stall <= 1;
        end else if (hold_go && !hold_done) begin
            hold_cnt <= 400;
            hold_done <= 1;
            i_out_stall <= 1;
        end else begin
            i_out_stall <= !quiet && ($urandom_range(0, 99) < 10);
        end
    end

    // watchdog
    always @(posedge i_clk) begin
        if ((i_in_valid && !o_in_stall) || (o_out_valid && !i_out_stall))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= 5000) begin
            $display("Test completed with failures");
            $finish;
        end
    end

    task automatic send_op(krb_pkg::t_mode mode, logic [LIST_W-1:0] lst,
                           logic [COUNT_W-1:0] cnt,
                           logic [KEY_W-1:0] key, logic [PAYLOAD_W-1:0] pay);
        if (!quiet && $urandom_range(0, 99) < 10) begin
            i_in_valid <= 0;
            repeat ($urandom_range(1, 4)) @(posedge i_clk);
        end
        i_in_valid   <= 1;
        i_mode       <= mode;
        i_list_id    <= lst;
        i_slot_count <= cnt;
        i_entry_key  <= key;
        i_payload_in <= pay;
        @(posedge i_clk);
        while (o_in_stall) @(posedge i_clk);
        ops_sent++;
        quiet = (ops_sent >= 60 && ops_sent < 130);
        if (ops_sent == 220) hold_go <= 1;
    endtask

    initial begin
        logic [KEY_W-1:0] keys[$];
        logic [KEY_W-1:0] k;
        logic [LIST_W-1:0] lst;
        int n, nins, sel, wait_cnt;
        bit dup;

        repeat (2) @(posedge i_clk);
        i_rst_n <= 1;
        @(posedge i_clk);

        // directed
        send_op(krb_pkg::MODE_OPEN, 8'd255, 6'd63, '0, '0);
        send_op(krb_pkg::MODE_OPEN, 8'd0, 6'd0, '0, '0);
        send_op(krb_pkg::MODE_INSERT, 8'd0, 6'd0, 32'h1234, '0);
        send_op(krb_pkg::MODE_DELIVER, 8'd0, 6'd0, 32'h1234, 32'h1);
        send_op(krb_pkg::MODE_OPEN, 8'd1, 6'd3, '0, '0);
        send_op(krb_pkg::MODE_INSERT, 8'd1, 6'd0, 32'hFFFF_FFFF, '0);
        send_op(krb_pkg::MODE_INSERT, 8'd1, 6'd0, 32'h0, '0);
        send_op(krb_pkg::MODE_INSERT, 8'd1, 6'd0, 32'h5, '0);
        send_op(krb_pkg::MODE_INSERT, 8'd1, 6'd0, 32'h7, '0);
        send_op(krb_pkg::MODE_INSERT, 8'd1, 6'd0, 32'hFFFF_FFFE, '0);
        send_op(krb_pkg::MODE_DELIVER, 8'd1, 6'd0, 32'h5, 32'hFFFF_FFFF);
        send_op(krb_pkg::MODE_DELIVER, 8'd1, 6'd0, 32'h5, 32'h0);
        send_op(krb_pkg::MODE_DELIVER, 8'd1, 6'd0, 32'h9, 32'h55);
        send_op(krb_pkg::MODE_DELIVER, 8'd1, 6'd0, 32'h0, 32'hA5A5_5A5A);
        send_op(krb_pkg::MODE_DELIVER, 8'd1, 6'd0, 32'h7, 32'h5A5A_A5A5);
        send_op(krb_pkg::MODE_DELIVER, 8'd1, 6'd0, 32'h7, 32'h77);
        send_op(krb_pkg::MODE_NONE, 8'd1, 6'd63, 32'h7, 32'h77);
        send_op(krb_pkg::MODE_DELIVER, 8'd255, 6'd0, 32'h7, 32'h77);

        // random well-formed lists with some noise
        while (ops_sent < 315) begin
            sel = $urandom_range(0, 99);
            lst = (sel < 70) ? LIST_W'($urandom_range(0, 7)) : (sel < 80) ? 8'd255
                : LIST_W'($urandom_range(0, 255));
            sel = $urandom_range(0, 99);
            n = (sel < 85) ? $urandom_range(1, 6) : (sel < 92) ? $urandom_range(0, 63) : 32;
            send_op(krb_pkg::MODE_OPEN, lst, COUNT_W'(n), $urandom, $urandom);
            if (n > krb_pkg::SLOTS_DEF) n = krb_pkg::SLOTS_DEF;
            nins = n;
            sel = $urandom_range(0, 99);
            if (sel < 25) nins = n + $urandom_range(1, 2);
            else if (sel < 40 && n > 0) nins = $urandom_range(0, n - 1);
            keys.delete();
            while (keys.size() < nins) begin
                k = $urandom;
                dup = 0;
                foreach (keys[i]) if (keys[i] == k) dup = 1;
                if (!dup) keys.push_back(k);
            end
            foreach (keys[i])
                send_op(krb_pkg::MODE_INSERT, lst, COUNT_W'($urandom), keys[i], $urandom);
            keys.shuffle();
            foreach (keys[i]) begin
                send_op(krb_pkg::MODE_DELIVER, lst, COUNT_W'($urandom), keys[i], $urandom);
                sel = $urandom_range(0, 99);
                if (sel < 8)
                    send_op(krb_pkg::MODE_DELIVER, lst, COUNT_W'($urandom),
                            keys[$urandom_range(0, i)], $urandom);
                else if (sel < 12)
                    send_op(krb_pkg::MODE_NONE, LIST_W'($urandom), COUNT_W'($urandom),
                            $urandom, $urandom);
                else if (sel < 16)
                    send_op(krb_pkg::MODE_DELIVER, lst, COUNT_W'($urandom), $urandom,
                            $urandom);
            end
        end
        i_in_valid <= 0;

        wait_cnt = 0;
        while (pending != 0 && wait_cnt < 20000) begin
            @(posedge i_clk);
            wait_cnt++;
        end
        repeat (150) @(posedge i_clk);

        $display("ran %0d operations over open, insert, deliver and unused mode;", ops_sent);
        $display("%0d entries committed, with random stalls and one long output hold-off",
                 commits);
        if (fail_cnt == 0 && pending == 0)
            $display("Test completed successfully");
        else
            $display("Test completed with failures");
        $finish;
    end

endmodule
